FILE: rtl/core/skx_pkg.sv
package skx_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned PosW  = 6;

  // table entries 1..55 are live, entry 0 is never touched
  localparam int unsigned TableDepth = 56;

  localparam logic [PosW-1:0] LAST_ENTRY    = 6'd55;
  localparam logic [PosW-1:0] POS_EXHAUSTED = 6'd56;
  localparam logic [PosW-1:0] FIRST_ENTRY   = 6'd1;
  localparam logic [PosW-1:0] SCHED_STRIDE  = 6'd21;
  // stride 21 from 21 up to 0x46E gives 54 writes
  localparam logic [PosW-1:0] SCHED_STEPS   = 6'd54;
  localparam logic [PosW-1:0] LOW_SPAN      = 6'd24;
  localparam logic [PosW-1:0] HIGH_SPAN     = 6'd31;
  localparam logic [1:0]      RESEED_PASSES = 2'd3;  // extra passes after the first

  typedef enum logic {
    ACT_RESEED = 1'b0,
    ACT_CRYPT  = 1'b1
  } action_e;

  typedef struct packed {
    action_e          action;
    logic [WordW-1:0] data_word;
    logic             end_of_buffer;
  } cmd_t;

endpackage

FILE: rtl/core/skx_ram.sv
module skx_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 56
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/skx_front.sv
module skx_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [31:0]    s_axis_tdata,
  input  logic           s_axis_tuser,
  input  logic           s_axis_tlast,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i,
  output skx_pkg::cmd_t  cmd_o
);
  import skx_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;
  cmd_t       cmd_in;

  always_comb begin
    cmd_in.action        = action_e'(s_axis_tuser);
    cmd_in.data_word     = s_axis_tdata;
    cmd_in.end_of_buffer = s_axis_tlast;
  end

  assign s_axis_tready = (count_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign cmd_valid_o   = (count_q != 2'd0);
  assign pop           = cmd_valid_o && cmd_ready_i;
  assign cmd_o         = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

FILE: rtl/core/skx_back.sv
module skx_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  output logic                 cmd_ready_o,
  input  skx_pkg::cmd_t        cmd_i,
  input  logic [31:0]          seed_key_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [31:0]          out_data_o,
  output logic                 out_last_o
);
  import skx_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_MIX,
    ST_DRAIN,
    ST_XOR
  } state_e;

  state_e           state_q;
  logic [PosW-1:0]  pos_q, e_q, sidx_q, cnt_q, mwa_q;
  logic [1:0]       pass_q;
  logic             pend_q, mv_q;
  logic [WordW-1:0] a_q, b_q;
  logic [WordW-1:0] data_q;
  logic             last_q;
  logic             out_valid_q, out_last_q;
  logic [WordW-1:0] out_data_q;
  logic [TableDepth-1:0] vld_q;
  logic             va_q, vb_q;

  logic             pop;
  logic [PosW-1:0]  ra_addr, rb_addr, wa_addr;
  logic             we;
  logic [WordW-1:0] wd;
  logic [WordW-1:0] rda, rdb, ka, kb;
  logic [PosW:0]    sidx_sum;
  logic [PosW-1:0]  sidx_next;

  assign pop = (state_q == ST_IDLE) && cmd_valid_i &&
               (cmd_i.action == ACT_RESEED || !out_valid_q || out_ready_i);
  assign cmd_ready_o = pop;

  // entries never written read as zero
  assign ka = va_q ? rda : '0;
  assign kb = vb_q ? rdb : '0;

  assign sidx_sum  = {1'b0, sidx_q} + {1'b0, SCHED_STRIDE};
  assign sidx_next = (sidx_sum >= {1'b0, LAST_ENTRY}) ?
                     PosW'(sidx_sum - {1'b0, LAST_ENTRY}) : sidx_sum[PosW-1:0];

  always_comb begin
    unique case (state_q)
      ST_IDLE:  ra_addr = pos_q;
      ST_DRAIN: ra_addr = FIRST_ENTRY;
      default:  ra_addr = e_q;
    endcase
    // entries 1..24 pair with the entry 31 above, the rest with the entry 24 below
    rb_addr = (e_q <= LOW_SPAN) ? (e_q + HIGH_SPAN) : (e_q - LOW_SPAN);

    we      = 1'b0;
    wa_addr = mwa_q;
    wd      = ka - kb;
    priority if (mv_q) begin
      we = 1'b1;
    end else if (state_q == ST_SEED) begin
      we      = 1'b1;
      wa_addr = sidx_q;
      wd      = a_q;
    end else if (pop && cmd_i.action == ACT_RESEED) begin
      we      = 1'b1;
      wa_addr = LAST_ENTRY;
      wd      = seed_key_i;
    end
  end

  skx_ram #(.Width(WordW), .Depth(TableDepth)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wa_addr),
    .wdata_i (wd),
    .raddr_i (ra_addr),
    .rdata_o (rda)
  );

  skx_ram #(.Width(WordW), .Depth(TableDepth)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wa_addr),
    .wdata_i (wd),
    .raddr_i (rb_addr),
    .rdata_o (rdb)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= POS_EXHAUSTED;
      vld_q       <= '0;
      mv_q        <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_last_q  <= 1'b0;
      pend_q      <= 1'b0;
      e_q         <= FIRST_ENTRY;
      pass_q      <= 2'd0;
      cnt_q       <= '0;
      sidx_q      <= SCHED_STRIDE;
      va_q        <= 1'b0;
      vb_q        <= 1'b0;
      mwa_q       <= FIRST_ENTRY;
    end else begin
      va_q <= vld_q[ra_addr];
      vb_q <= vld_q[rb_addr];
      if (we) begin
        vld_q[wa_addr] <= 1'b1;
      end
      mv_q  <= (state_q == ST_MIX);
      mwa_q <= e_q;
      if (state_q == ST_XOR) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (pop) begin
            if (cmd_i.action == ACT_RESEED) begin
              sidx_q  <= SCHED_STRIDE;
              cnt_q   <= SCHED_STEPS;
              state_q <= ST_SEED;
            end else if (pos_q == POS_EXHAUSTED) begin
              // table used up: remix once before reading entry 1
              e_q     <= FIRST_ENTRY;
              pass_q  <= 2'd0;
              pend_q  <= 1'b1;
              state_q <= ST_MIX;
            end else begin
              pos_q   <= pos_q + 6'd1;
              state_q <= ST_XOR;
            end
          end
        end
        ST_SEED: begin
          sidx_q <= sidx_next;
          cnt_q  <= cnt_q - 6'd1;
          if (cnt_q == 6'd1) begin
            e_q     <= FIRST_ENTRY;
            pass_q  <= RESEED_PASSES;
            pend_q  <= 1'b0;
            state_q <= ST_MIX;
          end
        end
        ST_MIX: begin
          if (e_q == LAST_ENTRY) begin
            e_q <= FIRST_ENTRY;
            if (pass_q == 2'd0) begin
              state_q <= ST_DRAIN;
            end else begin
              pass_q <= pass_q - 2'd1;
            end
          end else begin
            e_q <= e_q + 6'd1;
          end
        end
        ST_DRAIN: begin
          pos_q   <= pend_q ? (FIRST_ENTRY + 6'd1) : POS_EXHAUSTED;
          state_q <= pend_q ? ST_XOR : ST_IDLE;
        end
        ST_XOR: begin
          out_data_q <= data_q ^ ka;
          out_last_q <= last_q;
          state_q    <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      data_q <= cmd_i.data_word;
      last_q <= cmd_i.end_of_buffer;
    end
    if (pop && cmd_i.action == ACT_RESEED) begin
      a_q <= 32'd1;
      b_q <= seed_key_i;
    end else if (state_q == ST_SEED) begin
      a_q <= b_q - a_q;
      b_q <= a_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

endmodule

FILE: rtl/core/subtractive_keystream_xor.sv
// Channel   Direction  Handshake               Payload
// s_axis    in         s_axis_tvalid/tready    tdata data_word, tuser action, tlast end_of_buffer
// m_axis    out        m_axis_tvalid/tready    tdata data_out, tlast last
// apb       in         psel/penable, pready=1  seed_key at byte address 0
//
// A crypt word passes through the engine as a table read and then an XOR into the
// output register. The first crypt word after reset or a reseed, and every 55th
// after it, first remixes the table: 55 entries through a pipelined
// read-subtract-write loop plus a drain.
// A reseed: key into entry 55, 54 schedule writes, 4 passes of 55 mix steps, a drain.
// Reset is asynchronous; the table reads as zero until its entries are written.
// A two-word queue lets the input side run ahead of the engine; the engine
// holds a crypt word until the output register is free.
module subtractive_keystream_xor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] data_word
  input  logic        s_axis_tuser,   // [0] action
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] data_out
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import skx_pkg::*;

  localparam logic REG_SEED_KEY = 1'b0;

  logic [31:0] seed_key_q;
  logic        cmd_valid, cmd_ready;
  cmd_t        cmd;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SEED_KEY) ? seed_key_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_key_q <= 32'd0;
    end else if (psel && penable && pwrite && paddr[2] == REG_SEED_KEY) begin
      seed_key_q <= pwdata;
    end
  end

  skx_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .cmd_valid_o   (cmd_valid),
    .cmd_ready_i   (cmd_ready),
    .cmd_o         (cmd)
  );

  skx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .seed_key_i  (seed_key_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule
